// File: hw/rtl/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

	localparam int DEF_CODE_DIGITS = 4;

	localparam int CODE_W  = 16;
	localparam int LIMIT_W = 3;
	localparam int PHASE_W = 3;
	localparam int EVENT_W = 4;
	localparam int DISP_W  = 2;
	localparam int LEN_W   = 3;
	localparam int KIND_W  = 2;
	localparam int KEY_W   = 4;
	localparam int DIGIT_W = 4;

	// Session phases
	localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_VERIFY = 3'd1;
	localparam logic [PHASE_W-1:0] PH_CUR    = 3'd2;
	localparam logic [PHASE_W-1:0] PH_NEW    = 3'd3;
	localparam logic [PHASE_W-1:0] PH_CONF   = 3'd4;

	// Transaction kinds
	localparam logic [KIND_W-1:0] KIND_PRESS  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VERIFY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CHANGE = 2'd2;

	// Keys
	localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [KEY_W-1:0] KEY_BACK      = 4'd13;
	localparam logic [KEY_W-1:0] KEY_CANCEL    = 4'd14;

	// Result events
	localparam logic [EVENT_W-1:0] EV_PROGRESS  = 4'd0;
	localparam logic [EVENT_W-1:0] EV_CANCELLED = 4'd1;
	localparam logic [EVENT_W-1:0] EV_GRANTED   = 4'd2;
	localparam logic [EVENT_W-1:0] EV_RETRY     = 4'd3;
	localparam logic [EVENT_W-1:0] EV_DENIED    = 4'd4;
	localparam logic [EVENT_W-1:0] EV_WRONG_CUR = 4'd5;
	localparam logic [EVENT_W-1:0] EV_MISMATCH  = 4'd6;
	localparam logic [EVENT_W-1:0] EV_CHANGED   = 4'd7;
	localparam logic [EVENT_W-1:0] EV_IGNORED   = 4'd8;

	// Display actions
	localparam logic [DISP_W-1:0] DISP_NONE  = 2'd0;
	localparam logic [DISP_W-1:0] DISP_SHOW  = 2'd1;
	localparam logic [DISP_W-1:0] DISP_ERASE = 2'd2;

	// Configuration register indexes
	localparam logic CFG_INITIAL_CODE  = 1'b0;
	localparam logic CFG_ATTEMPT_LIMIT = 1'b1;

	localparam logic [CODE_W-1:0]  RST_INITIAL_CODE  = 16'h0000;
	localparam logic [LIMIT_W-1:0] RST_ATTEMPT_LIMIT = 3'd3;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [LIMIT_W-1:0] wrong;
		logic [CODE_W-1:0]  pending;
		logic               replaced;
		logic [CODE_W-1:0]  replaced_code;
	} lock_state_t;

	typedef struct packed {
		logic [CODE_W-1:0]  new_code;
		logic               session_active;
		logic [LIMIT_W-1:0] attempts_used;
		logic [LEN_W-1:0]   entered_length;
		logic [DISP_W-1:0]  display_action;
		logic [EVENT_W-1:0] event_res;
	} result_t;

	localparam int RES_W   = $bits(result_t);
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

// File: hw/rtl/kcl_step.sv
`timescale 1ns / 1ps

module kcl_step #(
	parameter int CODE_DIGITS = kcl_pkg::DEF_CODE_DIGITS,
	parameter int CNT_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1
) (
	input  logic [kcl_pkg::KIND_W-1:0]                       kind,
	input  logic [kcl_pkg::KEY_W-1:0]                        key,
	input  logic [kcl_pkg::CODE_W-1:0]                       initial_code,
	input  logic [kcl_pkg::LIMIT_W-1:0]                      attempt_limit,
	input  kcl_pkg::lock_state_t                             state_cur,
	input  logic [CNT_W-1:0]                                 count_cur,
	input  logic [CODE_DIGITS-1:0][kcl_pkg::DIGIT_W-1:0]     digits,
	output kcl_pkg::lock_state_t                             state_nxt,
	output logic [CNT_W-1:0]                                 count_nxt,
	output logic                                             digit_we,
	output kcl_pkg::result_t                                 result
);
	import kcl_pkg::*;

	localparam logic [CNT_W-1:0] LAST = CNT_W'(CODE_DIGITS - 1);
	localparam int PACK_W = 32;

	logic [PACK_W-1:0]  packed_val;
	logic [CODE_W-1:0]  entry_val;
	logic [CODE_W-1:0]  code_now;
	logic [LIMIT_W-1:0] lim;
	logic [LIMIT_W-1:0] wrong_inc;

	// The digit being typed completes the entry, so it takes the last slot.
	always_comb begin
		packed_val = '0;
		for (int i = 0; i < CODE_DIGITS; i++) begin
			if (i == CODE_DIGITS - 1) begin
				packed_val = {packed_val[PACK_W-DIGIT_W-1:0], key};
			end else begin
				packed_val = {packed_val[PACK_W-DIGIT_W-1:0], digits[i]};
			end
		end
	end

	assign entry_val = packed_val[CODE_W-1:0];
	assign code_now  = state_cur.replaced ? state_cur.replaced_code : initial_code;
	assign lim       = (attempt_limit == '0) ? LIMIT_W'(1) : attempt_limit;
	assign wrong_inc = state_cur.wrong + LIMIT_W'(1);

	logic [EVENT_W-1:0] ev;
	logic [DISP_W-1:0]  disp;
	logic [CODE_W-1:0]  newc;

	always_comb begin
		state_nxt = state_cur;
		count_nxt = count_cur;
		digit_we  = 1'b0;
		ev        = EV_PROGRESS;
		disp      = DISP_NONE;
		newc      = '0;
		if (kind == KIND_VERIFY || kind == KIND_CHANGE) begin
			state_nxt.phase = (kind == KIND_VERIFY) ? PH_VERIFY : PH_CUR;
			state_nxt.wrong = '0;
			count_nxt       = '0;
		end else if (state_cur.phase == PH_IDLE) begin
			ev = EV_IGNORED;
		end else if (kind == KIND_PRESS) begin
			if (key == KEY_CANCEL) begin
				state_nxt.phase = PH_IDLE;
				count_nxt       = '0;
				ev              = EV_CANCELLED;
			end else if (key == KEY_BACK) begin
				if (count_cur != '0) begin
					count_nxt = count_cur - CNT_W'(1);
					disp      = DISP_ERASE;
				end
			end else if (key <= KEY_DIGIT_MAX) begin
				digit_we = 1'b1;
				disp     = DISP_SHOW;
				if (count_cur == LAST) begin
					count_nxt = '0;
					case (state_cur.phase)
						PH_VERIFY: begin
							if (entry_val == code_now) begin
								ev              = EV_GRANTED;
								state_nxt.phase = PH_IDLE;
							end else begin
								state_nxt.wrong = wrong_inc;
								if (wrong_inc >= lim) begin
									ev              = EV_DENIED;
									state_nxt.phase = PH_IDLE;
								end else begin
									ev = EV_RETRY;
								end
							end
						end
						PH_CUR: begin
							if (entry_val == code_now) begin
								state_nxt.phase = PH_NEW;
							end else begin
								ev              = EV_WRONG_CUR;
								state_nxt.phase = PH_IDLE;
							end
						end
						PH_NEW: begin
							state_nxt.pending = entry_val;
							state_nxt.phase   = PH_CONF;
						end
						default: begin
							if (entry_val == state_cur.pending) begin
								state_nxt.replaced      = 1'b1;
								state_nxt.replaced_code = entry_val;
								newc                    = entry_val;
								ev                      = EV_CHANGED;
							end else begin
								ev = EV_MISMATCH;
							end
							state_nxt.phase = PH_IDLE;
						end
					endcase
				end else begin
					count_nxt = count_cur + CNT_W'(1);
				end
			end
		end
	end

	always_comb begin
		result.event_res      = ev;
		result.display_action = disp;
		result.entered_length = LEN_W'(count_nxt);
		result.attempts_used  = state_nxt.wrong;
		result.session_active = (state_nxt.phase != PH_IDLE);
		result.new_code       = newc;
	end

endmodule

// File: hw/rtl/keypad_code_lock_unit.sv
`timescale 1ns / 1ps

// Keypad code lock. Each input transaction is a key press or a command that
// starts a verify or change session; every transaction yields exactly one
// result transaction. Throughput is one transaction per cycle while the downstream
// side accepts results. The transaction is first held in an input register, then the
// session state is updated and the result is written to the output register
// in one pass through the step logic, whose longest path is the 16-bit compare
// of the packed entry against the code in force. The input register lets one
// further transaction in while a result is held by the downstream side.
// The code in force is initial_code until a change session succeeds; after
// that only a reset brings initial_code back. Configuration writes are meant
// for an idle block.

module keypad_code_lock_unit #(
	parameter int CODE_DIGITS = kcl_pkg::DEF_CODE_DIGITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [kcl_pkg::CODE_W-1:0]    cfg_wdata,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [3:0] key, [7:4] zero
	input  logic [kcl_pkg::KIND_W-1:0]    s_tuser,   // [1:0] kind
	// Result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [3:0] event_res, [5:4] display_action, [8:6] entered_length,
	// [11:9] attempts_used, [12] session_active, [28:13] new_code, rest zero
	output logic [kcl_pkg::TDATA_W-1:0]   m_tdata
);
	import kcl_pkg::*;

	localparam int CNT_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

	logic [CODE_W-1:0]  initial_code_q;
	logic [LIMIT_W-1:0] attempt_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_code_q  <= RST_INITIAL_CODE;
			attempt_limit_q <= RST_ATTEMPT_LIMIT;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_INITIAL_CODE:  initial_code_q  <= cfg_wdata;
				CFG_ATTEMPT_LIMIT: attempt_limit_q <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	logic               valid_s1;
	logic [KIND_W-1:0]  kind_s1;
	logic [KEY_W-1:0]   key_s1;
	logic               out_valid_q;
	result_t            res_q;
	logic               out_free;
	logic               fire;

	assign out_free = !out_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			key_s1  <= s_tdata[KEY_W-1:0];
		end
	end

	// Session state
	lock_state_t                           state_q;
	lock_state_t                           state_nxt;
	logic [CNT_W-1:0]                      count_q;
	logic [CNT_W-1:0]                      count_nxt;
	logic [CODE_DIGITS-1:0][DIGIT_W-1:0]   digits_q;
	logic                                  digit_we;
	result_t                               result;

	kcl_step #(
		.CODE_DIGITS(CODE_DIGITS),
		.CNT_W(CNT_W)
	) u_step (
		.kind(kind_s1),
		.key(key_s1),
		.initial_code(initial_code_q),
		.attempt_limit(attempt_limit_q),
		.state_cur(state_q),
		.count_cur(count_q),
		.digits(digits_q),
		.state_nxt(state_nxt),
		.count_nxt(count_nxt),
		.digit_we(digit_we),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (fire) begin
			state_q     <= state_nxt;
			count_q     <= count_nxt;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= result;
			if (digit_we) begin
				digits_q[count_q] <= key_s1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_W'(res_q);

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import kcl_pkg::*;

	localparam int NDIG = DEF_CODE_DIGITS;
	localparam int PHASE_ITEMS = 80;
	localparam int LIMIT_CYCLES = 200000;

	localparam logic [KEY_W-1:0] KEY_LETTER_A = 4'd10;
	localparam logic [KEY_W-1:0] KEY_HASH     = 4'd15;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		bit                typed;
		result_t           want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic                cfg_addr = CFG_INITIAL_CODE;
	logic [CODE_W-1:0]   cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic [KIND_W-1:0]   s_tuser = KIND_PRESS;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;

	keypad_code_lock_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Shadow of the lock: configuration and session state.
	logic [CODE_W-1:0]  cfg_code = RST_INITIAL_CODE;
	logic [LIMIT_W-1:0] cfg_limit = RST_ATTEMPT_LIMIT;
	logic [PHASE_W-1:0] lk_phase = PH_IDLE;
	logic [DIGIT_W-1:0] lk_digit [NDIG];
	logic [LEN_W-1:0]   lk_count = '0;
	logic [LIMIT_W-1:0] lk_wrong = '0;
	logic [CODE_W-1:0]  lk_pending = '0;
	logic               lk_replaced = 1'b0;
	logic [CODE_W-1:0]  lk_new_code = '0;

	result_t  replies_due [$];
	result_t  seen;
	result_t  want;
	dir_row_t dir_tab [25];
	int       errors = 0;
	int       cycles = 0;
	int       counted = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       confirm_ok_pct = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles >= LIMIT_CYCLES);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic result_t res_of(input logic [EVENT_W-1:0] ev, input logic [DISP_W-1:0] disp,
			input logic [LEN_W-1:0] len, input logic [LIMIT_W-1:0] att, input logic act,
			input logic [CODE_W-1:0] code);
		return result_t'{code, act, att, len, disp, ev};
	endfunction

	function automatic logic [CODE_W-1:0] code_in_force();
		return lk_replaced ? lk_new_code : cfg_code;
	endfunction

	function automatic logic [CODE_W-1:0] rand_code();
		logic [CODE_W-1:0] c;
		c = '0;
		for (int i = 0; i < NDIG; i++) c[4*i +: 4] = 4'($urandom_range(9));
		return c;
	endfunction

	// Advances the shadow lock by one input transaction and returns its reply.
	function automatic result_t next_reply(input logic [KIND_W-1:0] kind,
			input logic [KEY_W-1:0] key);
		result_t           r;
		logic [CODE_W-1:0] val;
		int                lim;
		r = '0;
		r.event_res = EV_PROGRESS;
		r.display_action = DISP_NONE;
		if (kind == KIND_VERIFY || kind == KIND_CHANGE) begin
			lk_phase = (kind == KIND_VERIFY) ? PH_VERIFY : PH_CUR;
			lk_count = '0;
			lk_wrong = '0;
		end else if (lk_phase == PH_IDLE) begin
			r.event_res = EV_IGNORED;
		end else if (kind == KIND_PRESS) begin
			if (key == KEY_CANCEL) begin
				lk_phase = PH_IDLE;
				lk_count = '0;
				r.event_res = EV_CANCELLED;
			end else if (key == KEY_BACK) begin
				if (lk_count > 0) begin
					lk_count = lk_count - 1'b1;
					r.display_action = DISP_ERASE;
				end
			end else if (key <= KEY_DIGIT_MAX && lk_count < NDIG) begin
				lk_digit[lk_count] = key;
				lk_count = lk_count + 1'b1;
				r.display_action = DISP_SHOW;
				if (lk_count == NDIG) begin
					// First digit typed lands in the most significant nibble.
					val = '0;
					for (int i = 0; i < NDIG; i++) val = {val[CODE_W-5:0], lk_digit[i]};
					lk_count = '0;
					case (lk_phase)
						PH_VERIFY: begin
							if (val == code_in_force()) begin
								r.event_res = EV_GRANTED;
								lk_phase = PH_IDLE;
							end else begin
								lim = (cfg_limit == 0) ? 1 : cfg_limit;
								lk_wrong = lk_wrong + 1'b1;
								if (lk_wrong >= lim) begin
									r.event_res = EV_DENIED;
									lk_phase = PH_IDLE;
								end else begin
									r.event_res = EV_RETRY;
								end
							end
						end
						PH_CUR: begin
							if (val == code_in_force()) begin
								lk_phase = PH_NEW;
							end else begin
								r.event_res = EV_WRONG_CUR;
								lk_phase = PH_IDLE;
							end
						end
						PH_NEW: begin
							lk_pending = val;
							lk_phase = PH_CONF;
						end
						default: begin
							if (val == lk_pending) begin
								lk_new_code = val;
								lk_replaced = 1'b1;
								r.new_code = val;
								r.event_res = EV_CHANGED;
							end else begin
								r.event_res = EV_MISMATCH;
							end
							lk_phase = PH_IDLE;
						end
					endcase
				end
			end
		end
		r.entered_length = lk_count;
		r.attempts_used = lk_wrong;
		r.session_active = (lk_phase != PH_IDLE);
		return r;
	endfunction

	task automatic check_field(input string what, input logic [CODE_W-1:0] exp_v,
			input logic [CODE_W-1:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			$display("%0t ns: %s expected %0h, got %0h", $time, what, exp_v, got_v);
		end
	endtask

	// Result side: random back-pressure and in-order comparison.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen = result_t'(m_tdata[RES_W-1:0]);
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t ns: result %h with nothing expected, got %h",
					$time, 32'h0, m_tdata);
			end else begin
				want = replies_due.pop_front();
				check_field("event_res", want.event_res, seen.event_res);
				check_field("display_action", want.display_action, seen.display_action);
				check_field("entered_length", want.entered_length, seen.entered_length);
				check_field("attempts_used", want.attempts_used, seen.attempts_used);
				check_field("session_active", want.session_active, seen.session_active);
				check_field("new_code", want.new_code, seen.new_code);
				check_field("padding", '0, 16'(m_tdata >> RES_W));
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Offers one transaction, waits for it to be taken and books its reply.
	task automatic press(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
		result_t r;
		if ($urandom_range(199) == 0) begin
			// Hold off until the block has answered everything sent so far.
			s_tvalid <= 1'b0;
			do @(posedge clk); while (replies_due.size() != 0);
		end
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'b0000, key};
		do @(posedge clk); while (!s_tready);
		r = next_reply(kind, key);
		replies_due.push_back(r);
		if (r.event_res != EV_IGNORED) counted++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CODE_W-1:0] code, input logic [LIMIT_W-1:0] lim);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_INITIAL_CODE;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_code = code;
		cfg_addr <= CFG_ATTEMPT_LIMIT;
		cfg_wdata <= {{(CODE_W-LIMIT_W){1'b0}}, lim};
		@(posedge clk);
		cfg_limit = lim;
		cfg_we <= 1'b0;
	endtask

	// Types a code digit by digit, with stray letters and corrected slips mixed in.
	task automatic type_code(input logic [CODE_W-1:0] code);
		logic [DIGIT_W-1:0] d;
		for (int i = 0; i < NDIG; i++) begin
			d = code[4*(NDIG-1-i) +: 4];
			// A nibble above nine cannot be typed, so such a code is entered wrongly.
			if (d > KEY_DIGIT_MAX) d = 4'($urandom_range(9));
			if ($urandom_range(99) < 8)
				press(KIND_PRESS, ($urandom_range(3) == 0) ? KEY_HASH
					: 4'(KEY_LETTER_A + $urandom_range(2)));
			if (i < NDIG - 1 && $urandom_range(99) < 6) begin
				press(KIND_PRESS, 4'($urandom_range(9)));
				press(KIND_PRESS, KEY_BACK);
			end
			press(KIND_PRESS, d);
		end
	endtask

	task automatic verify_session();
		int n;
		int r;
		press(KIND_VERIFY, 4'($urandom_range(15)));
		n = 0;
		while (lk_phase != PH_IDLE && n < 9) begin
			r = $urandom_range(99);
			if (r < 7) begin
				repeat ($urandom_range(3)) press(KIND_PRESS, 4'($urandom_range(9)));
				if (r < 4) press(KIND_PRESS, KEY_CANCEL);
				else press(KIND_VERIFY, 4'($urandom_range(15)));
			end else begin
				type_code((r < 45) ? code_in_force() : rand_code());
			end
			n++;
		end
	endtask

	task automatic change_session();
		logic [CODE_W-1:0] fresh;
		press(KIND_CHANGE, 4'($urandom_range(15)));
		type_code(($urandom_range(99) < 80) ? code_in_force() : rand_code());
		if (lk_phase == PH_NEW) begin
			fresh = rand_code();
			if ($urandom_range(99) < 5) begin
				press(KIND_PRESS, KEY_CANCEL);
			end else begin
				type_code(fresh);
				if ($urandom_range(99) >= confirm_ok_pct)
					fresh[3:0] = (fresh[3:0] == 4'd9) ? 4'd0 : fresh[3:0] + 4'd1;
				type_code(fresh);
			end
		end
	endtask

	task automatic run_phase(input logic [CODE_W-1:0] code, input logic [LIMIT_W-1:0] lim,
			input int s_idle, input int r_stall, input int ok_pct);
		int r;
		drain();
		cfg_write(code, lim);
		send_idle_pct = s_idle;
		recv_stall_pct = r_stall;
		confirm_ok_pct = ok_pct;
		counted = 0;
		while (counted < PHASE_ITEMS) begin
			r = $urandom_range(99);
			if (r < 15) begin
				repeat ($urandom_range(1, 6))
					press(2'($urandom_range(2)), 4'($urandom_range(15)));
			end else if (r < 55) begin
				verify_session();
			end else begin
				change_session();
			end
		end
	endtask

	initial begin
		// Directed run against the reset settings: code 0000, three attempts.
		dir_tab = '{
			'{KIND_PRESS,  4'd5,         1'b1, res_of(EV_IGNORED, DISP_NONE, 0, 0, 0, '0)},
			'{KIND_VERIFY, KEY_HASH,     1'b1, res_of(EV_PROGRESS, DISP_NONE, 0, 0, 1, '0)},
			'{KIND_PRESS,  KEY_BACK,     1'b1, res_of(EV_PROGRESS, DISP_NONE, 0, 0, 1, '0)},
			'{KIND_PRESS,  4'd0,         1'b0, '0},
			'{KIND_PRESS,  KEY_LETTER_A, 1'b0, '0},
			'{KIND_PRESS,  KEY_HASH,     1'b0, '0},
			'{KIND_PRESS,  KEY_BACK,     1'b0, '0},
			'{KIND_PRESS,  4'd9,         1'b0, '0},
			'{KIND_PRESS,  4'd9,         1'b0, '0},
			'{KIND_PRESS,  4'd9,         1'b0, '0},
			'{KIND_PRESS,  4'd9,         1'b1, res_of(EV_RETRY, DISP_SHOW, 0, 1, 1, '0)},
			'{KIND_PRESS,  KEY_CANCEL,   1'b1, res_of(EV_CANCELLED, DISP_NONE, 0, 1, 0, '0)},
			'{KIND_CHANGE, 4'd0,         1'b1, res_of(EV_PROGRESS, DISP_NONE, 0, 0, 1, '0)},
			'{KIND_PRESS,  4'd0,         1'b0, '0},
			'{KIND_PRESS,  4'd0,         1'b0, '0},
			'{KIND_PRESS,  4'd0,         1'b0, '0},
			'{KIND_PRESS,  4'd0,         1'b0, '0},
			'{KIND_PRESS,  4'd9,         1'b0, '0},
			'{KIND_PRESS,  4'd8,         1'b0, '0},
			'{KIND_PRESS,  4'd7,         1'b0, '0},
			'{KIND_PRESS,  4'd6,         1'b0, '0},
			'{KIND_PRESS,  4'd9,         1'b0, '0},
			'{KIND_PRESS,  4'd8,         1'b0, '0},
			'{KIND_PRESS,  4'd7,         1'b0, '0},
			'{KIND_PRESS,  4'd5,         1'b1, res_of(EV_MISMATCH, DISP_SHOW, 0, 0, 0, '0)}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			press(dir_tab[i].kind, dir_tab[i].key);
			if (dir_tab[i].typed) replies_due[$] = dir_tab[i].want;
		end
		// Early phases never confirm a new code, so initial_code stays in force.
		run_phase(16'h1234, 3'd7, 0, 0, 0);
		run_phase(16'hFFFF, 3'd1, 54, 0, 0);
		run_phase(16'h0000, 3'd3, 0, 54, 0);
		run_phase(16'h9055, 3'd5, 31, 31, 70);
		run_phase(16'h4711, 3'd1, 31, 31, 70);
		drain();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: keypad_code_lock_unit.f
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_step.sv
hw/rtl/keypad_code_lock_unit.sv
dv/tb.sv
